// ===== sv/acache_pkg.sv =====
// Shared types and constants for the associative cache with replacement.
package acache_pkg;
	localparam int ENTRIES = 16;
	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int KEY_W = 32;
	localparam int CFG_W = 5;

	localparam logic [CFG_W-1:0] REG_POLICY = CFG_W'(0);
	localparam logic [CFG_W-1:0] REG_CAPACITY = CFG_W'(1);

	localparam logic [1:0] POL_OLDEST = 2'd0;
	localparam logic [1:0] POL_NEWEST = 2'd1;
	localparam logic [1:0] POL_LFU = 2'd2;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_OUT} state_t;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic             hit;
		logic [IDX_W-1:0] hit_idx;
		logic             have_best;
		logic [IDX_W-1:0] best_idx;
		logic [31:0]      best_val;
		logic [KEY_W-1:0] best_key;
	} probe_t;

	typedef struct packed {
		logic             en;
		logic             fresh;
		logic [IDX_W-1:0] idx;
		logic [KEY_W-1:0] key;
		logic [31:0]      stamp;
	} upd_t;
endpackage

// ===== sv/acache_cell.sv =====
// One cache slot: stored entry, match and victim compare on the passing probe.
module acache_cell import acache_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] idx,
	input  logic [CNT_W-1:0] fill,
	input  logic [1:0]       policy,
	input  probe_t           probe_in,
	input  upd_t             upd,
	output probe_t           probe_out
);
	logic [KEY_W-1:0] key_q;
	logic [31:0]      cnt_q;
	logic [31:0]      stamp_q;
	logic             active;
	logic             match;
	logic [31:0]      metric;
	logic             better;
	probe_t           next_probe;

	always_comb begin
		active = {1'b0, idx} < fill;
		match = active && (key_q == probe_in.key);
		metric = (policy == POL_LFU) ? cnt_q : stamp_q;
		case (policy)
			POL_NEWEST: better = metric > probe_in.best_val;
			POL_LFU: better = metric < probe_in.best_val;
			default: better = metric < probe_in.best_val;
		endcase
		next_probe = probe_in;
		if (match && !probe_in.hit) begin
			next_probe.hit = 1'b1;
			next_probe.hit_idx = idx;
		end
		if (active && (!probe_in.have_best || better)) begin
			next_probe.have_best = 1'b1;
			next_probe.best_idx = idx;
			next_probe.best_val = metric;
			next_probe.best_key = key_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_out <= '0;
		end else begin
			probe_out <= next_probe;
		end
	end

	always_ff @(posedge clk) begin
		if (upd.en && upd.idx == idx) begin
			if (upd.fresh) begin
				key_q <= upd.key;
				cnt_q <= 32'd1;
				stamp_q <= upd.stamp;
			end else if (cnt_q != '1) begin
				cnt_q <= cnt_q + 32'd1;
			end
		end
	end
endmodule

// ===== sv/assoc_cache_with_replacement.sv =====
// Top level: fully associative cache with FIFO, LIFO or LFU replacement.
// Usage: present a key on the input channel (in_valid, in_stall, key).
// The key travels down a chain of ENTRIES slot cells, one cell a cycle,
// gathering the first matching slot and the victim candidate. When it
// leaves the last cell the result is registered and the chosen slot is
// updated: access count bumped on a hit, or the entry rewritten on a miss.
// out_valid is registered from the output of the last cell, and only
// one transaction is in flight at a time.
// The result (hit, slot, evicted, evicted_key) holds while out_stall is
// high; in_stall stays high until the result is taken.
// Configuration: cfg_we with cfg_index 0 (policy) or 1 (capacity), only
// while idle. Reset clears the fill count, the stamp counter and the
// handshake state; policy returns to oldest-first and capacity to 16.
// Slot contents are not cleared; only filled slots are ever looked at.
module assoc_cache_with_replacement import acache_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [KEY_W-1:0] key,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             hit,
	output logic [IDX_W-1:0] slot,
	output logic             evicted,
	output logic [KEY_W-1:0] evicted_key,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);
	state_t           state_q;
	state_t           state_nxt;
	logic [1:0]       policy_q;
	logic [CFG_W-1:0] capacity_q;
	logic [CNT_W-1:0] fill_q;
	logic [31:0]      stamp_q;
	logic [CNT_W-1:0] cap_eff;
	logic             accept;
	logic             done;
	probe_t           probe_s [ENTRIES+1];
	probe_t           pe;
	upd_t             upd;

	assign accept = in_valid && !in_stall;
	assign pe = probe_s[ENTRIES];
	assign done = pe.valid;

	always_comb begin
		probe_s[0] = '0;
		probe_s[0].valid = accept;
		probe_s[0].key = key;
	end

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		acache_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (IDX_W'(g)),
			.fill     (fill_q),
			.policy   (policy_q),
			.probe_in (probe_s[g]),
			.upd      (upd),
			.probe_out(probe_s[g+1])
		);
	end

	always_comb begin
		if (capacity_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (32'(capacity_q) > ENTRIES) begin
			cap_eff = CNT_W'(ENTRIES);
		end else begin
			cap_eff = CNT_W'(capacity_q);
		end
	end

	always_comb begin
		upd = '0;
		upd.en = done;
		upd.key = pe.key;
		upd.stamp = stamp_q;
		if (pe.hit) begin
			upd.idx = pe.hit_idx;
		end else if (fill_q < cap_eff) begin
			upd.fresh = 1'b1;
			upd.idx = IDX_W'(fill_q);
		end else begin
			upd.fresh = 1'b1;
			upd.idx = pe.best_idx;
		end
	end

	always_comb begin
		state_nxt = state_q;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (done) begin
					state_nxt = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_stall) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			policy_q <= POL_OLDEST;
			capacity_q <= CFG_W'(16);
			fill_q <= '0;
			stamp_q <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				case (cfg_index)
					REG_POLICY[0:0]: policy_q <= cfg_data[1:0];
					REG_CAPACITY[0:0]: capacity_q <= cfg_data;
					default: ;
				endcase
			end
			if (done) begin
				out_valid <= 1'b1;
				if (!pe.hit) begin
					stamp_q <= stamp_q + 32'd1;
					if (fill_q < cap_eff) begin
						fill_q <= fill_q + CNT_W'(1);
					end
				end
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			hit <= pe.hit;
			slot <= upd.idx;
			evicted <= !pe.hit && !(fill_q < cap_eff);
			evicted_key <= (!pe.hit && !(fill_q < cap_eff)) ? pe.best_key : '0;
		end
	end
endmodule

// ===== sv/acache_checker.sv =====
// Port-level checker for the associative cache, bound to the top level.
module acache_checker import acache_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic             hit,
	input logic             evicted,
	input logic [KEY_W-1:0] evicted_key
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped under stall");
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !out_valid)
		else $error("result too early");
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> !evicted)
		else $error("eviction on hit");
	a_evkey_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !evicted |-> evicted_key == '0)
		else $error("evicted key not zero");
endmodule

bind assoc_cache_with_replacement acache_checker u_acache_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.hit        (hit),
	.evicted    (evicted),
	.evicted_key(evicted_key)
);
